FILE: hdl/net_half_perimeter_wirelength_unit_macros.svh
// Assertion macros shared by the wirelength unit RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef NET_HALF_PERIMETER_WIRELENGTH_UNIT_MACROS_SVH
`define NET_HALF_PERIMETER_WIRELENGTH_UNIT_MACROS_SVH

`ifndef SYNTH
// Plain property, disabled during reset.
`define HPWL_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("hpwl check failed");
// Same-cycle implication.
`define HPWL_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("hpwl check failed");
// Next-cycle implication.
`define HPWL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("hpwl check failed");
`else
`define HPWL_ASSERT(lbl, clk_s, rst_s, prop)
`define HPWL_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define HPWL_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

FILE: hdl/hpwl_pkg.sv
// Shared types and constants for the half perimeter wirelength unit.
// No dependencies; compile first.
package hpwl_pkg;

    localparam int COMP_W   = 31;
    localparam int OFS_W    = 23;
    localparam int COORD_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int LEN_W    = 33;
    localparam int WLEN_W   = 49;
    localparam int TOTAL_W  = 63;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [1:0]         MIN_PINS  = 2'd2;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // One closed net, handed from the box tracker to the length pipeline.
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_y;
        logic [WEIGHT_W-1:0]       weight;
        logic                      counted;
        logic                      clear;
    } net_rec_t;

    // Push side of the net queue.
    typedef struct packed {
        logic     push;
        net_rec_t rec;
    } net_push_t;

endpackage

FILE: hdl/hpwl_pin_if.sv
// Pin channel: valid/ready handshake carrying one pin transaction.
// Depends on hpwl_pkg for field widths.
interface hpwl_pin_if;
    import hpwl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [OFS_W-1:0]  pin_dx;
    logic signed [OFS_W-1:0]  pin_dy;
    logic                     first_pin;
    logic                     last_pin;
    logic [WEIGHT_W-1:0]      net_weight;
    logic                     net_excluded;
    logic                     start_of_pass;

    modport source (
        output valid, comp_x, comp_y, pin_dx, pin_dy, first_pin, last_pin,
               net_weight, net_excluded, start_of_pass,
        input  ready
    );
    modport sink (
        input  valid, comp_x, comp_y, pin_dx, pin_dy, first_pin, last_pin,
               net_weight, net_excluded, start_of_pass,
        output ready
    );
endinterface

FILE: hdl/hpwl_net_if.sv
// Net result channel: valid/ready handshake carrying one net transaction.
// Depends on hpwl_pkg for field widths.
interface hpwl_net_if;
    import hpwl_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEN_W-1:0]   net_length;
    logic [WLEN_W-1:0]  weighted_length;
    logic [TOTAL_W-1:0] running_total;
    logic               net_counted;

    modport source (
        output valid, net_length, weighted_length, running_total, net_counted,
        input  ready
    );
    modport sink (
        input  valid, net_length, weighted_length, running_total, net_counted,
        output ready
    );
endinterface

FILE: hdl/hpwl_front.sv
// Front end: takes pin transactions, forms pin points, tracks the net box.
// Depends on hpwl_pkg, hpwl_pin_if and the assertion macros header.
`include "net_half_perimeter_wirelength_unit_macros.svh"

module hpwl_front (
    input  logic                clk,
    input  logic                rst_n,
    hpwl_pin_if.sink            pins,
    input  logic                q_full,
    output hpwl_pkg::net_push_t push
);
    import hpwl_pkg::*;

    logic signed [COORD_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [COORD_W-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
    logic signed [COORD_W-1:0] px, py;
    logic [1:0]                pins_seen_reg, pins_seen_next;
    logic                      clear_pend_reg;
    logic                      restart;
    logic                      accept;

    assign pins.ready = !q_full;
    assign accept     = pins.valid && pins.ready;

    assign px = {pins.comp_x[COMP_W-1], pins.comp_x}
              + {{(COORD_W-OFS_W){pins.pin_dx[OFS_W-1]}}, pins.pin_dx};
    assign py = {pins.comp_y[COMP_W-1], pins.comp_y}
              + {{(COORD_W-OFS_W){pins.pin_dy[OFS_W-1]}}, pins.pin_dy};

    // A pin with no open net starts one, as does an explicit first pin.
    assign restart = pins.first_pin || (pins_seen_reg == 2'd0);

    always_comb
    begin
        if (restart)
        begin
            min_x_next     = px;
            max_x_next     = px;
            min_y_next     = py;
            max_y_next     = py;
            pins_seen_next = 2'd1;
        end
        else
        begin
            min_x_next     = (px < min_x_reg) ? px : min_x_reg;
            max_x_next     = (px > max_x_reg) ? px : max_x_reg;
            min_y_next     = (py < min_y_reg) ? py : min_y_reg;
            max_y_next     = (py > max_y_reg) ? py : max_y_reg;
            pins_seen_next = (pins_seen_reg < MIN_PINS) ? pins_seen_reg + 2'd1
                                                        : pins_seen_reg;
        end
    end

    always_comb
    begin
        push.push        = accept && pins.last_pin;
        push.rec.min_x   = min_x_next;
        push.rec.max_x   = max_x_next;
        push.rec.min_y   = min_y_next;
        push.rec.max_y   = max_y_next;
        push.rec.weight  = pins.net_weight;
        push.rec.counted = (pins_seen_next >= MIN_PINS) && !pins.net_excluded;
        push.rec.clear   = clear_pend_reg || pins.start_of_pass;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
        end
    end

    // Hold a start-of-pass seen mid-net until the net closes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pins_seen_reg  <= 2'd0;
            clear_pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (pins.last_pin)
            begin
                pins_seen_reg  <= 2'd0;
                clear_pend_reg <= 1'b0;
            end
            else
            begin
                pins_seen_reg  <= pins_seen_next;
                clear_pend_reg <= clear_pend_reg || pins.start_of_pass;
            end
        end
    end

    `HPWL_ASSERT(a_pins_sat, clk, rst_n, pins_seen_reg != 2'd3)
    `HPWL_ASSERT_NEXT(a_close_net, clk, rst_n, accept && pins.last_pin,
                      pins_seen_reg == 2'd0 && !clear_pend_reg)
    `HPWL_ASSERT_IMPL(a_box_order, clk, rst_n, pins_seen_reg != 2'd0,
                      min_x_reg <= max_x_reg && min_y_reg <= max_y_reg)

endmodule

FILE: hdl/hpwl_queue.sv
// Short register queue of closed nets between the front and back ends.
// Depends on hpwl_pkg and the assertion macros header.
`include "net_half_perimeter_wirelength_unit_macros.svh"

module hpwl_queue #(
    parameter int QUEUE_DEPTH = hpwl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hpwl_pkg::net_push_t push,
    output logic                full,
    output logic                pop_valid,
    input  logic                pop,
    output hpwl_pkg::net_rec_t  pop_rec
);
    import hpwl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    net_rec_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_rec   = entry_reg[rd_ptr_reg];
    assign do_push   = push.push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `HPWL_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH))
    `HPWL_ASSERT_IMPL(a_no_overflow, clk, rst_n, push.push, !full)
    `HPWL_ASSERT_NEXT(a_count_up, clk, rst_n, do_push && !do_pop,
                      count_reg == $past(count_reg) + CNT_W'(1))

endmodule

FILE: hdl/hpwl_back.sv
// Back end: box extents to half perimeter, weight multiply, saturating total.
// Depends on hpwl_pkg, hpwl_net_if and the assertion macros header.
`include "net_half_perimeter_wirelength_unit_macros.svh"

module hpwl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  hpwl_pkg::net_rec_t q_rec,
    output logic               q_pop,
    hpwl_net_if.source         nets
);
    import hpwl_pkg::*;

    // Stage 1: box width and height
    logic                s1_valid_reg;
    logic [COORD_W-1:0]  s1_wx_reg, s1_wy_reg;
    logic [WEIGHT_W-1:0] s1_weight_reg;
    logic                s1_counted_reg, s1_clear_reg;
    // Stage 2: half perimeter
    logic                s2_valid_reg;
    logic [LEN_W-1:0]    s2_len_reg;
    logic [WEIGHT_W-1:0] s2_weight_reg;
    logic                s2_counted_reg, s2_clear_reg;
    // Stage 3: weighted length
    logic                s3_valid_reg;
    logic [LEN_W-1:0]    s3_len_reg;
    logic [WLEN_W-1:0]   s3_wlen_reg;
    logic                s3_counted_reg, s3_clear_reg;
    // Output stage; the total register doubles as running_total.
    logic                out_valid_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [WLEN_W-1:0]   out_wlen_reg;
    logic                out_counted_reg;
    logic [TOTAL_W-1:0]  total_reg;

    logic                adv;
    logic [TOTAL_W-1:0]  total_base;
    logic [TOTAL_W:0]    total_sum;
    logic [TOTAL_W-1:0]  total_next;

    // Advance the whole pipeline unless a result is held at the output.
    assign adv   = !out_valid_reg || nets.ready;
    assign q_pop = adv;

    assign total_base = s3_clear_reg ? '0 : total_reg;
    assign total_sum  = {1'b0, total_base} + (TOTAL_W + 1)'(s3_wlen_reg);
    assign total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_wx_reg      <= COORD_W'(q_rec.max_x - q_rec.min_x);
            s1_wy_reg      <= COORD_W'(q_rec.max_y - q_rec.min_y);
            s1_weight_reg  <= q_rec.weight;
            s1_counted_reg <= q_rec.counted;
            s1_clear_reg   <= q_rec.clear;

            s2_len_reg     <= s1_counted_reg ? ({1'b0, s1_wx_reg} + {1'b0, s1_wy_reg})
                                             : '0;
            s2_weight_reg  <= s1_weight_reg;
            s2_counted_reg <= s1_counted_reg;
            s2_clear_reg   <= s1_clear_reg;

            s3_len_reg     <= s2_len_reg;
            s3_wlen_reg    <= WLEN_W'(s2_len_reg) * WLEN_W'(s2_weight_reg);
            s3_counted_reg <= s2_counted_reg;
            s3_clear_reg   <= s2_clear_reg;

            if (s3_valid_reg)
            begin
                out_len_reg     <= s3_len_reg;
                out_wlen_reg    <= s3_wlen_reg;
                out_counted_reg <= s3_counted_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s3_valid_reg)
            begin
                total_reg <= total_next;
            end
        end
    end

    assign nets.valid           = out_valid_reg;
    assign nets.net_length      = out_len_reg;
    assign nets.weighted_length = out_wlen_reg;
    assign nets.running_total   = total_reg;
    assign nets.net_counted     = out_counted_reg;

    `HPWL_ASSERT_IMPL(a_uncounted_zero, clk, rst_n, out_valid_reg && !out_counted_reg,
                      out_len_reg == '0 && out_wlen_reg == '0)
    `HPWL_ASSERT_NEXT(a_total_grows, clk, rst_n, adv && s3_valid_reg && !s3_clear_reg,
                      total_reg >= $past(total_reg))
    `HPWL_ASSERT_NEXT(a_total_hold, clk, rst_n, !(adv && s3_valid_reg),
                      total_reg == $past(total_reg))

endmodule

FILE: hdl/net_half_perimeter_wirelength_unit.sv
// Top level of the half perimeter wirelength unit.
// Depends on hpwl_pkg, hpwl_pin_if, hpwl_net_if, hpwl_front, hpwl_queue, hpwl_back.

// Pins stream in one transaction per cycle, grouped by net; the box tracker
// forms the pin point and updates the bounding box as each pin is accepted.
// A net's last pin drops its box into a queue of QUEUE_DEPTH entries; the
// back end takes the net whenever its pipeline advances, and its four stages
// (extents, half perimeter, Q8.8 weight multiply, saturating total) carry the
// result through in that order to the output register. Sustained rate is one
// pin per cycle; the queue lets pins keep flowing while a result waits at the
// output, and the pin channel stalls only when QUEUE_DEPTH closed nets are
// waiting. Nets with fewer than two pins or marked excluded still produce a
// result, with zero length and a total that is unchanged unless the net starts
// a pass, which clears it.
module net_half_perimeter_wirelength_unit #(
    parameter int QUEUE_DEPTH = hpwl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    hpwl_pin_if.sink   pins,
    hpwl_net_if.source nets
);
    import hpwl_pkg::*;

    net_push_t push;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;
    net_rec_t  q_rec;

    hpwl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pins   (pins),
        .q_full (q_full),
        .push   (push)
    );

    hpwl_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_rec   (q_rec)
    );

    hpwl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_rec   (q_rec),
        .q_pop   (q_pop),
        .nets    (nets)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for net_half_perimeter_wirelength_unit.
// Depends on hpwl_pkg, hpwl_pin_if and hpwl_net_if from the RTL; drives pin
// transactions, predicts each net result and checks it at the result port.
module tb;
    import hpwl_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     DRAIN_CYCLES   = 16;
    localparam int     FULL_SPAN_NETS = 100;
    localparam longint COMP_LO        = -(longint'(1) <<< (COMP_W - 1));
    localparam longint COMP_HI        = (longint'(1) << (COMP_W - 1)) - 1;
    localparam longint OFS_LO         = -(longint'(1) <<< (OFS_W - 1));
    localparam longint OFS_HI         = (longint'(1) << (OFS_W - 1)) - 1;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [OFS_W-1:0]  pin_dx;
        logic signed [OFS_W-1:0]  pin_dy;
        logic                     first_pin;
        logic                     last_pin;
        logic [WEIGHT_W-1:0]      net_weight;
        logic                     net_excluded;
        logic                     start_of_pass;
    } pin_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]   net_length;
        logic [WLEN_W-1:0]  weighted_length;
        logic [TOTAL_W-1:0] running_total;
        logic               net_counted;
    } net_result_t;

    logic clk = 1'b0;
    logic rst_n;

    hpwl_pin_if pin_ch();
    hpwl_net_if net_ch();

    net_half_perimeter_wirelength_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pins  (pin_ch),
        .nets  (net_ch)
    );

    always #5 clk = ~clk;

    // Predicted state of the box tracker and the pass total.
    logic signed [COORD_W-1:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;
    logic [1:0]                pins_in_net;
    logic [TOTAL_W-1:0]        pass_total;

    net_result_t net_results_due[$];
    net_result_t seen_result, due_result;
    int          mismatch_count = 0;
    int          stall_cycles   = 0;
    int          sink_stall_left = 0;
    bit          source_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic longint rand_field(input int w);
        longint lo;
        lo = -(longint'(1) <<< (w - 1));
        case ($urandom_range(0, 9))
            0: return lo;
            1: return -lo - 1;
            2, 3, 4: return longint'($urandom_range(0, 4000)) - 2000;
            default: return longint'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 16'h0100;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic pin_item_t make_pin(input longint cx, cy, dx, dy,
                                           input bit first, last,
                                           input logic [WEIGHT_W-1:0] w,
                                           input bit excl, start);
        pin_item_t p;
        p.comp_x        = cx[COMP_W-1:0];
        p.comp_y        = cy[COMP_W-1:0];
        p.pin_dx        = dx[OFS_W-1:0];
        p.pin_dy        = dy[OFS_W-1:0];
        p.first_pin     = first;
        p.last_pin      = last;
        p.net_weight    = w;
        p.net_excluded  = excl;
        p.start_of_pass = start;
        return p;
    endfunction

    // Advance the predicted box and total by one pin; queue a result on a last pin.
    function automatic void track_pin(input pin_item_t p);
        logic signed [COORD_W-1:0] px, py;
        logic [LEN_W-1:0]          span;
        logic [63:0]               product;
        logic [63:0]               headroom;
        net_result_t               r;
        px = p.comp_x + p.pin_dx;
        py = p.comp_y + p.pin_dy;
        if (p.start_of_pass)
            pass_total = '0;
        if (p.first_pin || pins_in_net == 2'd0)
        begin
            box_lo_x    = px;
            box_hi_x    = px;
            box_lo_y    = py;
            box_hi_y    = py;
            pins_in_net = 2'd1;
        end
        else
        begin
            if (px < box_lo_x) box_lo_x = px;
            if (px > box_hi_x) box_hi_x = px;
            if (py < box_lo_y) box_lo_y = py;
            if (py > box_hi_y) box_hi_y = py;
            if (pins_in_net < MIN_PINS)
                pins_in_net = pins_in_net + 2'd1;
        end
        if (!p.last_pin)
            return;
        r = '0;
        r.net_counted = (pins_in_net >= MIN_PINS) && !p.net_excluded;
        if (r.net_counted)
        begin
            span = LEN_W'(longint'(box_hi_x) - longint'(box_lo_x)
                          + longint'(box_hi_y) - longint'(box_lo_y));
            product = 64'(span) * 64'(p.net_weight);
            r.net_length      = span;
            r.weighted_length = product[WLEN_W-1:0];
            headroom = 64'(TOTAL_MAX) - 64'(pass_total);
            if (64'(r.weighted_length) > headroom)
                pass_total = TOTAL_MAX;
            else
                pass_total = pass_total + TOTAL_W'(r.weighted_length);
        end
        r.running_total = pass_total;
        net_results_due.push_back(r);
        pins_in_net = 2'd0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("tb: mismatch on %s: expected 0x%0h, got 0x%0h at %0t",
                     what, want, got, $time);
    endtask

    // Drive one pin transaction at the falling edge and hold it until accepted.
    task automatic send_pin(input pin_item_t p);
        int gap;
        gap = source_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            pin_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin_ch.valid         <= 1'b1;
        pin_ch.comp_x        <= p.comp_x;
        pin_ch.comp_y        <= p.comp_y;
        pin_ch.pin_dx        <= p.pin_dx;
        pin_ch.pin_dy        <= p.pin_dy;
        pin_ch.first_pin     <= p.first_pin;
        pin_ch.last_pin      <= p.last_pin;
        pin_ch.net_weight    <= p.net_weight;
        pin_ch.net_excluded  <= p.net_excluded;
        pin_ch.start_of_pass <= p.start_of_pass;
        do @(posedge clk); while (!pin_ch.ready);
        track_pin(p);
    endtask

    // Hold the pin channel idle until every predicted net result has arrived.
    task automatic hold_until_drained();
        @(negedge clk);
        pin_ch.valid <= 1'b0;
        while (net_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_open_net_rules();
        // pins with no first_pin open a net after reset and after a last pin
        send_pin(make_pin(100, 200, 3, -4, 0, 0, 16'h0100, 0, 0));
        send_pin(make_pin(-50, 7, 0, 0, 0, 1, 16'h0100, 0, 0));
        send_pin(make_pin(9, 9, 1, 1, 0, 1, 16'hFFFF, 0, 0));
        // one-pin net
        send_pin(make_pin(-9, 5, -1, 2, 1, 1, 16'hFFFF, 0, 0));
        // first_pin in the middle of a net restarts the box
        send_pin(make_pin(0, 0, 0, 0, 1, 0, 16'h0000, 0, 0));
        send_pin(make_pin(1000, 1000, 0, 0, 1, 0, 16'h0000, 1, 0));
        send_pin(make_pin(-300, 40, 5, 5, 0, 1, 16'h0180, 0, 0));
        // power plane net
        send_pin(make_pin(10, 10, 0, 0, 1, 0, 16'h0100, 0, 0));
        send_pin(make_pin(500, -500, 0, 0, 0, 1, 16'h0100, 1, 0));
    endtask

    task automatic test_coordinate_extremes();
        send_pin(make_pin(COMP_LO, COMP_LO, OFS_LO, OFS_LO, 1, 0, 16'h0000, 0, 0));
        send_pin(make_pin(COMP_HI, COMP_HI, OFS_HI, OFS_HI, 0, 1, 16'hFFFF, 0, 0));
        send_pin(make_pin(COMP_HI, COMP_LO, OFS_LO, OFS_HI, 1, 0, 16'hFFFF, 1, 0));
        send_pin(make_pin(COMP_LO, COMP_HI, OFS_HI, OFS_LO, 0, 0, 16'hFFFF, 1, 0));
        send_pin(make_pin(0, 0, 0, 0, 0, 1, 16'h0000, 0, 0));
        send_pin(make_pin(-7, -7, 7, 7, 1, 0, 16'h0001, 0, 0));
        send_pin(make_pin(-7, -7, 7, 7, 0, 1, 16'h0001, 0, 0));
        send_pin(make_pin(COMP_HI, COMP_HI, OFS_LO, OFS_LO, 1, 0, 16'h0000, 0, 0));
        send_pin(make_pin(COMP_LO, COMP_LO, OFS_HI, OFS_HI, 0, 1, 16'h0001, 0, 0));
    endtask

    task automatic test_pass_restart();
        send_pin(make_pin(10, 20, 0, 0, 1, 0, 16'h0000, 0, 1));
        send_pin(make_pin(30, 50, 0, 0, 0, 1, 16'h0200, 0, 0));
        // clear on a last pin, then add this net
        send_pin(make_pin(0, 0, 0, 0, 1, 0, 16'h0000, 0, 0));
        send_pin(make_pin(100, 0, 0, 0, 0, 1, 16'h0100, 0, 1));
        send_pin(make_pin(3, 3, 0, 0, 1, 1, 16'hFFFF, 0, 1));
        send_pin(make_pin(5, 5, 0, 0, 1, 0, 16'h0100, 0, 0));
        send_pin(make_pin(6, 6, 0, 0, 0, 1, 16'h0100, 1, 1));
    endtask

    task automatic send_random_net(output int npins);
        logic [WEIGHT_W-1:0] w;
        bit                  excl;
        int                  pass_start_at;
        npins = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(2, 4);
        w     = rand_weight();
        excl  = ($urandom_range(0, 7) == 0);
        pass_start_at = ($urandom_range(0, 14) == 0) ? $urandom_range(0, npins - 1) : -1;
        for (int k = 0; k < npins; k++)
            send_pin(make_pin(rand_field(COMP_W), rand_field(COMP_W),
                              rand_field(OFS_W), rand_field(OFS_W),
                              k == 0, k == npins - 1,
                              (k == npins - 1) ? w : rand_weight(),
                              (k == npins - 1) ? excl : bit'($urandom_range(0, 1)),
                              k == pass_start_at));
    endtask

    // Flag bits drawn at random: broken nets, stray restarts and orphan pins.
    task automatic send_noise_pins(output int npins);
        npins = $urandom_range(1, 4);
        for (int k = 0; k < npins; k++)
            send_pin(make_pin(rand_field(COMP_W), rand_field(COMP_W),
                              rand_field(OFS_W), rand_field(OFS_W),
                              $urandom_range(0, 1), $urandom_range(0, 1),
                              rand_weight(), $urandom_range(0, 1),
                              $urandom_range(0, 9) == 0));
    endtask

    task automatic test_random_nets(input int n_items);
        int sent;
        int block;
        int npins;
        sent  = 0;
        block = -1;
        while (sent < n_items)
        begin
            // switch idling on and off in blocks so some stretches run flat out
            if (sent / 100 != block)
            begin
                block = sent / 100;
                source_gaps_on = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) < 8)
                send_random_net(npins);
            else
                send_noise_pins(npins);
            sent += npins;
        end
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // Open a pass, run maximum-length nets flat out, then an excluded net and a pass restart.
    task automatic test_full_span_nets();
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        send_pin(make_pin(0, 0, 0, 0, 1, 1, 16'h0000, 0, 1));
        for (int n = 0; n < FULL_SPAN_NETS; n++)
        begin
            send_pin(make_pin(COMP_LO, COMP_LO, OFS_LO, OFS_LO, 1, 0, 16'h0000, 0, 0));
            send_pin(make_pin(COMP_HI, COMP_HI, OFS_HI, OFS_HI, 0, 1, 16'hFFFF, 0, 0));
        end
        source_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        send_pin(make_pin(COMP_LO, 0, 0, 0, 1, 0, 16'hFFFF, 0, 0));
        send_pin(make_pin(COMP_HI, 0, 0, 0, 0, 1, 16'hFFFF, 1, 0));
        send_pin(make_pin(-20, 0, 0, 0, 1, 0, 16'h0000, 0, 0));
        send_pin(make_pin(20, 0, 0, 0, 0, 1, 16'h0100, 0, 1));
    endtask

    // Result sink: random stalls on ready, changed at the falling edge.
    always @(negedge clk)
    begin
        if (sink_stall_left > 0)
        begin
            net_ch.ready <= 1'b0;
            sink_stall_left--;
        end
        else
        begin
            sink_stall_left = sink_stalls_on ? pick_gap() : 0;
            net_ch.ready <= (sink_stall_left == 0);
            if (sink_stall_left > 0)
                sink_stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && net_ch.valid && net_ch.ready)
        begin
            seen_result.net_length      = net_ch.net_length;
            seen_result.weighted_length = net_ch.weighted_length;
            seen_result.running_total   = net_ch.running_total;
            seen_result.net_counted     = net_ch.net_counted;
            if (net_results_due.size() == 0)
                flag_mismatch("result with none due", '0, 64'(seen_result.net_length));
            else
            begin
                due_result = net_results_due.pop_front();
                if (seen_result.net_length !== due_result.net_length)
                    flag_mismatch("net_length", 64'(due_result.net_length),
                                  64'(seen_result.net_length));
                if (seen_result.weighted_length !== due_result.weighted_length)
                    flag_mismatch("weighted_length", 64'(due_result.weighted_length),
                                  64'(seen_result.weighted_length));
                if (seen_result.running_total !== due_result.running_total)
                    flag_mismatch("running_total", 64'(due_result.running_total),
                                  64'(seen_result.running_total));
                if (seen_result.net_counted !== due_result.net_counted)
                    flag_mismatch("net_counted", 64'(due_result.net_counted),
                                  64'(seen_result.net_counted));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pin_ch.valid && pin_ch.ready) || (net_ch.valid && net_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        do @(posedge clk); while (stall_cycles < WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        box_lo_x             = '0;
        box_hi_x             = '0;
        box_lo_y             = '0;
        box_hi_y             = '0;
        pins_in_net          = '0;
        pass_total           = '0;
        pin_ch.valid         = 1'b0;
        pin_ch.comp_x        = '0;
        pin_ch.comp_y        = '0;
        pin_ch.pin_dx        = '0;
        pin_ch.pin_dy        = '0;
        pin_ch.first_pin     = 1'b0;
        pin_ch.last_pin      = 1'b0;
        pin_ch.net_weight    = '0;
        pin_ch.net_excluded  = 1'b0;
        pin_ch.start_of_pass = 1'b0;
        net_ch.ready         = 1'b0;
        rst_n                = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_open_net_rules();
        test_coordinate_extremes();
        test_pass_restart();
        hold_until_drained();
        test_random_nets(1300);
        hold_until_drained();
        test_full_span_nets();
        hold_until_drained();

        if (mismatch_count == 0 && net_results_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
